// ===== rtl/core/fcl_pkg.sv =====
// ----------------------------------------------------------------------------
// fcl_pkg: shared types and constants of the FOC current loop
// Payload structs, sequencer states, MAC micro-op decode, CORDIC arctangent
// table and the fixed-point constants of the transforms.
// ----------------------------------------------------------------------------
package fcl_pkg;

	localparam int FRACTION_BITS = 12;
	localparam int CORDIC_STEPS  = 16;
	localparam int CORDIC_ITERS  = (CORDIC_STEPS < 31) ? CORDIC_STEPS : 31;
	localparam logic [4:0] CORDIC_LAST = 5'(CORDIC_ITERS - 1);

	// datapath widths
	localparam int XY_W    = 34;
	localparam int TRIG_W  = 27;
	localparam int MUL_A_W = 40;
	localparam int MUL_B_W = 27;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int ACC_W   = PROD_W + 1;
	localparam int DIV_Q_W = 38;
	localparam int VN_W    = DIV_Q_W + 1;
	localparam int VOUT_W  = 40;
	localparam int DUTY_W  = 44;

	localparam logic [5:0] DIV_LAST = 6'(DIV_Q_W - 1);

	localparam logic signed [XY_W-1:0]    CORDIC_GAIN_Q30   = XY_W'(652032874);
	localparam logic signed [MUL_A_W-1:0] INV_SQRT3_Q30     = MUL_A_W'(619925131);
	localparam logic signed [MUL_A_W-1:0] TWO_INV_SQRT3_Q30 = MUL_A_W'(1239850262);
	localparam logic signed [MUL_B_W-1:0] HALF_SQRT3_Q24    = MUL_B_W'(14529495);
	localparam logic signed [MUL_B_W-1:0] UNIT_Q23          = MUL_B_W'(8388608);
	localparam logic [DIV_Q_W-1:0]        NORM_LIMIT        = DIV_Q_W'(64'd1 << 37);

	localparam logic [1:0] MODE_CURRENT = 2'd0;
	localparam logic [1:0] MODE_LOCK    = 2'd1;

	localparam logic [2:0] REG_MODE  = 3'd0;
	localparam logic [2:0] REG_KP    = 3'd1;
	localparam logic [2:0] REG_KI    = 3'd2;
	localparam logic [2:0] REG_KD    = 3'd3;
	localparam logic [2:0] REG_DLIM  = 3'd4;
	localparam logic [2:0] REG_QLIM  = 3'd5;

	localparam logic [4:0] UOP_PID_END = 5'd11;
	localparam logic [4:0] UOP_INV     = 5'd12;
	localparam logic [4:0] UOP_END     = 5'd17;

	typedef struct packed {
		logic signed [31:0] rotor_angle;
		logic signed [23:0] phase_a_current;
		logic signed [23:0] phase_c_current;
		logic signed [23:0] d_current_target;
		logic signed [23:0] q_current_target;
		logic signed [23:0] d_voltage_target;
		logic signed [23:0] q_voltage_target;
		logic [22:0]        bus_voltage;
		logic               clear_pid;
	} item_t;

	typedef struct packed {
		logic [15:0]        duty_a;
		logic [15:0]        duty_b;
		logic [15:0]        duty_c;
		logic signed [23:0] d_current;
		logic signed [23:0] q_current;
		logic signed [23:0] d_voltage;
		logic signed [23:0] q_voltage;
	} result_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CORDIC, ST_TRIG, ST_MAC, ST_PIDW,
		ST_DIV_INIT, ST_DIV_STEP, ST_DIV_END, ST_DRAIN, ST_FIN
	} state_t;

	typedef struct packed {
		logic take;
		logic cordic_step;
		logic trig_load;
		logic issue;
		logic div_init;
		logic div_step;
		logic div_end;
		logic fin_load;
	} seq_ctl_t;

	typedef enum logic [3:0] {
		A_K1, A_K2, A_IA, A_BETA, A_G0, A_G1, A_G2, A_VDN, A_VQN, A_VALPHA, A_VBETA
	} a_sel_t;

	typedef enum logic [3:0] {
		B_IA, B_IC, B_COS, B_SIN, B_ED, B_ED1, B_ED2, B_EQ, B_EQ1, B_EQ2, B_HALF, B_UNIT23
	} b_sel_t;

	typedef enum logic [2:0] {
		D_BETA, D_ID, D_IQ, D_PIDD, D_PIDQ, D_VALPHA, D_VBETA, D_VC
	} dst_t;

	typedef struct packed {
		a_sel_t a_sel;
		b_sel_t b_sel;
		logic   sub;
		logic   first;
		logic   last;
		dst_t   dst;
	} uop_t;

	function automatic uop_t uop_decode(input logic [4:0] u);
		uop_t o;
		o.a_sel = A_K1;
		o.b_sel = B_IA;
		o.sub   = 1'b0;
		o.first = 1'b0;
		o.last  = 1'b0;
		o.dst   = D_BETA;
		case (u)
			5'd0: begin o.a_sel = A_K1; o.b_sel = B_IA; o.first = 1'b1; o.dst = D_BETA; end
			5'd1: begin o.a_sel = A_K2; o.b_sel = B_IC; o.last = 1'b1; o.dst = D_BETA; end
			5'd2: begin o.a_sel = A_IA; o.b_sel = B_COS; o.first = 1'b1; o.dst = D_ID; end
			5'd3: begin o.a_sel = A_BETA; o.b_sel = B_SIN; o.last = 1'b1; o.dst = D_ID; end
			5'd4: begin o.a_sel = A_BETA; o.b_sel = B_COS; o.first = 1'b1; o.dst = D_IQ; end
			5'd5: begin
				o.a_sel = A_IA; o.b_sel = B_SIN; o.sub = 1'b1; o.last = 1'b1; o.dst = D_IQ;
			end
			5'd6: begin o.a_sel = A_G0; o.b_sel = B_ED; o.first = 1'b1; o.dst = D_PIDD; end
			5'd7: begin o.a_sel = A_G1; o.b_sel = B_ED1; o.sub = 1'b1; o.dst = D_PIDD; end
			5'd8: begin o.a_sel = A_G2; o.b_sel = B_ED2; o.last = 1'b1; o.dst = D_PIDD; end
			5'd9: begin o.a_sel = A_G0; o.b_sel = B_EQ; o.first = 1'b1; o.dst = D_PIDQ; end
			5'd10: begin o.a_sel = A_G1; o.b_sel = B_EQ1; o.sub = 1'b1; o.dst = D_PIDQ; end
			5'd11: begin o.a_sel = A_G2; o.b_sel = B_EQ2; o.last = 1'b1; o.dst = D_PIDQ; end
			5'd12: begin o.a_sel = A_VDN; o.b_sel = B_SIN; o.first = 1'b1; o.dst = D_VBETA; end
			5'd13: begin o.a_sel = A_VQN; o.b_sel = B_COS; o.last = 1'b1; o.dst = D_VBETA; end
			5'd14: begin o.a_sel = A_VDN; o.b_sel = B_COS; o.first = 1'b1; o.dst = D_VALPHA; end
			5'd15: begin
				o.a_sel = A_VQN; o.b_sel = B_SIN; o.sub = 1'b1; o.last = 1'b1;
				o.dst = D_VALPHA;
			end
			5'd16: begin o.a_sel = A_VBETA; o.b_sel = B_HALF; o.first = 1'b1; o.dst = D_VC; end
			5'd17: begin
				o.a_sel = A_VALPHA; o.b_sel = B_UNIT23; o.sub = 1'b1; o.last = 1'b1;
				o.dst = D_VC;
			end
			default: begin o.first = 1'b0; end
		endcase
		return o;
	endfunction

	// rounding half-LSB that seeds each accumulation
	function automatic logic signed [ACC_W-1:0] round_seed(input dst_t d);
		logic signed [ACC_W-1:0] r;
		case (d)
			D_BETA: r = ACC_W'(64'd1 << 29);
			D_PIDD, D_PIDQ: r = ACC_W'(64'd1 << 15);
			default: r = ACC_W'(64'd1 << 23);
		endcase
		return r;
	endfunction

	function automatic logic [30:0] atan_q31(input logic [4:0] i);
		logic [30:0] a;
		case (i)
			5'd0: a = 31'd536870912;
			5'd1: a = 31'd316933406;
			5'd2: a = 31'd167458907;
			5'd3: a = 31'd85004756;
			5'd4: a = 31'd42667331;
			5'd5: a = 31'd21354465;
			5'd6: a = 31'd10679838;
			5'd7: a = 31'd5340245;
			5'd8: a = 31'd2670163;
			5'd9: a = 31'd1335087;
			5'd10: a = 31'd667544;
			5'd11: a = 31'd333772;
			5'd12: a = 31'd166886;
			5'd13: a = 31'd83443;
			5'd14: a = 31'd41722;
			5'd15: a = 31'd20861;
			5'd16: a = 31'd10430;
			5'd17: a = 31'd5215;
			5'd18: a = 31'd2608;
			5'd19: a = 31'd1304;
			5'd20: a = 31'd652;
			5'd21: a = 31'd326;
			5'd22: a = 31'd163;
			5'd23: a = 31'd81;
			5'd24: a = 31'd41;
			5'd25: a = 31'd20;
			5'd26: a = 31'd10;
			5'd27: a = 31'd5;
			5'd28: a = 31'd3;
			5'd29: a = 31'd1;
			5'd30: a = 31'd1;
			default: a = 31'd0;
		endcase
		return a;
	endfunction

	function automatic logic signed [23:0] sat24(input logic signed [43:0] v);
		logic signed [23:0] r;
		if (v > 44'sd8388607) begin
			r = 24'sh7FFFFF;
		end else if (v < -44'sd8388608) begin
			r = 24'sh800000;
		end else begin
			r = v[23:0];
		end
		return r;
	endfunction

	// (v + 1) / 2 in Q0.16 with rounding, saturated
	function automatic logic [15:0] duty_of(input logic signed [DUTY_W-1:0] v);
		logic signed [DUTY_W-1:0] t;
		logic signed [DUTY_W-1:0] s;
		logic [15:0] r;
		t = v + DUTY_W'(64'd1 << 30) + DUTY_W'(64'd1 << 14);
		s = t >>> 15;
		if (s < 0) begin
			r = 16'd0;
		end else if (s > DUTY_W'(65535)) begin
			r = 16'hFFFF;
		end else begin
			r = s[15:0];
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/foc_current_loop.sv =====
// ----------------------------------------------------------------------------
// foc_current_loop: one field-oriented control update per PWM period
// CORDIC sin/cos, Clarke/Park, incremental PID per axis, bus normalization,
// inverse Park/Clarke and duty generation; all products share one MAC.
// ----------------------------------------------------------------------------
// Each transfer on the item channel runs a full update; the block takes no new
// item until the update has finished. The update time, in current mode as in
// phase-lock or open-loop voltage mode, is set mostly by the bit-serial
// divider, which computes v * 2^30 / bus for each axis, plus 16 CORDIC
// rotations and the products on the single 40x27 multiplier. The finished
// result waits in an output register, so the next item is accepted while the
// previous result is still pending; the block stalls only if a second result
// is ready before the first is taken. Configuration registers sit on an APB
// port at byte addresses 0 to 20 in steps of 4; the user must write them
// only while no update runs, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
module foc_current_loop (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	output logic                   item_ready,
	input  fcl_pkg::item_t         item,
	output logic                   result_valid,
	input  logic                   result_ready,
	output fcl_pkg::result_t       result,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [4:0]             paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);

	// configuration registers
	logic [1:0]  mode_q;
	logic [23:0] kp_q, ki_q, kd_q;
	logic [22:0] dlim_q, qlim_q;

	// sequencer
	fcl_pkg::state_t  state_q, state_d;
	fcl_pkg::seq_ctl_t ctl;

	// captured item and results
	fcl_pkg::item_t   item_q;
	fcl_pkg::result_t result_q;
	logic             result_valid_q;

	// CORDIC
	logic signed [fcl_pkg::XY_W-1:0] x_q, y_q, z_q;
	logic [4:0]  it_q;
	logic        flip_q;
	logic signed [fcl_pkg::TRIG_W-1:0] cs_q, sn_q;

	// transform and PID values
	logic signed [25:0] beta_q;
	logic signed [23:0] id_q, iq_q, vd_q, vq_q;
	logic signed [24:0] ed1_q, ed2_q, eq1_q, eq2_q;
	logic signed [31:0] yd_q, yq_q;
	logic signed [fcl_pkg::VN_W-1:0]   vdn_q, vqn_q;
	logic signed [fcl_pkg::VOUT_W-1:0] valpha_q, vbeta_q, vc_q;

	// multiply-accumulate
	logic [4:0]   uop_q;
	fcl_pkg::uop_t uop, uop_s1;
	logic         v_s1;
	logic signed [fcl_pkg::MUL_A_W-1:0] mul_a;
	logic signed [fcl_pkg::MUL_B_W-1:0] mul_b;
	logic signed [fcl_pkg::PROD_W-1:0]  prod_s1;
	logic signed [fcl_pkg::ACC_W-1:0]   acc_q, acc_base, acc_new;

	// divider
	logic        div_sel_q, neg_q, ovf_q;
	logic [5:0]  dc_q;
	logic [22:0] rem_q;
	logic [fcl_pkg::DIV_Q_W-1:0] nsh_q, quo_q;

	// ------------------------------------------------------------------------
	// APB register file; pready tied high, writes on the access phase
	// ------------------------------------------------------------------------
	logic       apb_wr;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign apb_wr  = psel & penable & pwrite & pready;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= fcl_pkg::MODE_CURRENT;
			kp_q   <= 24'd393216;
			ki_q   <= 24'd66;
			kd_q   <= 24'd0;
			dlim_q <= 23'(64'd10 << fcl_pkg::FRACTION_BITS);
			qlim_q <= 23'(64'd10 << fcl_pkg::FRACTION_BITS);
		end else if (apb_wr) begin
			case (reg_idx)
				fcl_pkg::REG_MODE: mode_q <= pwdata[1:0];
				fcl_pkg::REG_KP:   kp_q   <= pwdata[23:0];
				fcl_pkg::REG_KI:   ki_q   <= pwdata[23:0];
				fcl_pkg::REG_KD:   kd_q   <= pwdata[23:0];
				fcl_pkg::REG_DLIM: dlim_q <= pwdata[22:0];
				fcl_pkg::REG_QLIM: qlim_q <= pwdata[22:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			fcl_pkg::REG_MODE: prdata = {30'd0, mode_q};
			fcl_pkg::REG_KP:   prdata = {8'd0, kp_q};
			fcl_pkg::REG_KI:   prdata = {8'd0, ki_q};
			fcl_pkg::REG_KD:   prdata = {8'd0, kd_q};
			fcl_pkg::REG_DLIM: prdata = {9'd0, dlim_q};
			fcl_pkg::REG_QLIM: prdata = {9'd0, qlim_q};
			default:           prdata = 32'd0;
		endcase
	end

	// ------------------------------------------------------------------------
	// Sequencer: next state
	// ------------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			fcl_pkg::ST_IDLE: begin
				if (item_valid) state_d = fcl_pkg::ST_CORDIC;
			end
			fcl_pkg::ST_CORDIC: begin
				if (it_q == fcl_pkg::CORDIC_LAST) state_d = fcl_pkg::ST_TRIG;
			end
			fcl_pkg::ST_TRIG: begin
				state_d = (mode_q == fcl_pkg::MODE_CURRENT) ? fcl_pkg::ST_MAC
					: fcl_pkg::ST_DIV_INIT;
			end
			fcl_pkg::ST_MAC: begin
				if (uop_q == fcl_pkg::UOP_PID_END) state_d = fcl_pkg::ST_PIDW;
				else if (uop_q == fcl_pkg::UOP_END) state_d = fcl_pkg::ST_DRAIN;
			end
			fcl_pkg::ST_PIDW:     state_d = fcl_pkg::ST_DIV_INIT;
			fcl_pkg::ST_DIV_INIT: state_d = fcl_pkg::ST_DIV_STEP;
			fcl_pkg::ST_DIV_STEP: begin
				if (ovf_q || dc_q == fcl_pkg::DIV_LAST) state_d = fcl_pkg::ST_DIV_END;
			end
			fcl_pkg::ST_DIV_END: begin
				state_d = div_sel_q ? fcl_pkg::ST_MAC : fcl_pkg::ST_DIV_INIT;
			end
			fcl_pkg::ST_DRAIN: state_d = fcl_pkg::ST_FIN;
			fcl_pkg::ST_FIN: begin
				if (!result_valid_q || result_ready) state_d = fcl_pkg::ST_IDLE;
			end
			default: state_d = fcl_pkg::ST_IDLE;
		endcase
	end

	// Sequencer: strobes for the datapath
	always_comb begin
		ctl = '0;
		case (state_q)
			fcl_pkg::ST_IDLE:     ctl.take        = 1'b1;
			fcl_pkg::ST_CORDIC:   ctl.cordic_step = 1'b1;
			fcl_pkg::ST_TRIG:     ctl.trig_load   = 1'b1;
			fcl_pkg::ST_MAC:      ctl.issue       = 1'b1;
			fcl_pkg::ST_DIV_INIT: ctl.div_init    = 1'b1;
			fcl_pkg::ST_DIV_STEP: ctl.div_step    = 1'b1;
			fcl_pkg::ST_DIV_END:  ctl.div_end     = 1'b1;
			fcl_pkg::ST_FIN:      ctl.fin_load    = !result_valid_q || result_ready;
			default:              ctl = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fcl_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign item_ready = ctl.take;
	logic item_xfer;
	assign item_xfer = item_valid & ctl.take;

	// ------------------------------------------------------------------------
	// CORDIC: one rotation per cycle; phase lock rotates from angle zero
	// ------------------------------------------------------------------------
	logic [31:0] angle;
	logic        flip;
	logic signed [fcl_pkg::XY_W-1:0] dx, dy, at, xf, yf;

	assign angle = (mode_q == fcl_pkg::MODE_LOCK) ? 32'd0 : item.rotor_angle;
	assign flip  = angle[31] ^ angle[30];
	assign dx    = y_q >>> it_q;
	assign dy    = x_q >>> it_q;
	assign at    = {3'b000, fcl_pkg::atan_q31(it_q)};
	assign xf    = flip_q ? -x_q : x_q;
	assign yf    = flip_q ? -y_q : y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			it_q <= 5'd0;
		end else if (item_xfer) begin
			it_q <= 5'd0;
		end else if (ctl.cordic_step) begin
			it_q <= it_q + 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (item_xfer) begin
			flip_q <= flip;
			x_q    <= fcl_pkg::CORDIC_GAIN_Q30;
			y_q    <= '0;
			z_q    <= fcl_pkg::XY_W'($signed({angle[31] ^ flip, angle[30:0]}));
		end else if (ctl.cordic_step) begin
			if (z_q >= 0) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end
		end
		// undo the half-turn fold, then round Q30 to Q24
		if (ctl.trig_load) begin
			cs_q <= fcl_pkg::TRIG_W'((xf + fcl_pkg::XY_W'(32)) >>> 6);
			sn_q <= fcl_pkg::TRIG_W'((yf + fcl_pkg::XY_W'(32)) >>> 6);
		end
	end

	// ------------------------------------------------------------------------
	// Shared MAC: in the MAC state issue one product per cycle, accumulate it
	// the next cycle. The micro-op order reads no result before it is written.
	// ------------------------------------------------------------------------
	logic [25:0] g0, g1, g2;
	logic signed [24:0] ed, eq;

	assign g0  = 26'(kp_q) + 26'(ki_q) + 26'(kd_q);
	assign g1  = 26'(kp_q) + {1'b0, kd_q, 1'b0};
	assign g2  = 26'(kd_q);
	assign ed  = 25'(item_q.d_current_target) - 25'(id_q);
	assign eq  = 25'(item_q.q_current_target) - 25'(iq_q);
	assign uop = fcl_pkg::uop_decode(uop_q);

	always_comb begin
		case (uop.a_sel)
			fcl_pkg::A_K1:     mul_a = fcl_pkg::INV_SQRT3_Q30;
			fcl_pkg::A_K2:     mul_a = fcl_pkg::TWO_INV_SQRT3_Q30;
			fcl_pkg::A_IA:     mul_a = fcl_pkg::MUL_A_W'(item_q.phase_a_current);
			fcl_pkg::A_BETA:   mul_a = fcl_pkg::MUL_A_W'(beta_q);
			fcl_pkg::A_G0:     mul_a = $signed(fcl_pkg::MUL_A_W'(g0));
			fcl_pkg::A_G1:     mul_a = $signed(fcl_pkg::MUL_A_W'(g1));
			fcl_pkg::A_G2:     mul_a = $signed(fcl_pkg::MUL_A_W'(g2));
			fcl_pkg::A_VDN:    mul_a = fcl_pkg::MUL_A_W'(vdn_q);
			fcl_pkg::A_VQN:    mul_a = fcl_pkg::MUL_A_W'(vqn_q);
			fcl_pkg::A_VALPHA: mul_a = valpha_q;
			fcl_pkg::A_VBETA:  mul_a = vbeta_q;
			default:           mul_a = '0;
		endcase
	end

	always_comb begin
		case (uop.b_sel)
			fcl_pkg::B_IA:     mul_b = fcl_pkg::MUL_B_W'(item_q.phase_a_current);
			fcl_pkg::B_IC:     mul_b = fcl_pkg::MUL_B_W'(item_q.phase_c_current);
			fcl_pkg::B_COS:    mul_b = cs_q;
			fcl_pkg::B_SIN:    mul_b = sn_q;
			fcl_pkg::B_ED:     mul_b = fcl_pkg::MUL_B_W'(ed);
			fcl_pkg::B_ED1:    mul_b = fcl_pkg::MUL_B_W'(ed1_q);
			fcl_pkg::B_ED2:    mul_b = fcl_pkg::MUL_B_W'(ed2_q);
			fcl_pkg::B_EQ:     mul_b = fcl_pkg::MUL_B_W'(eq);
			fcl_pkg::B_EQ1:    mul_b = fcl_pkg::MUL_B_W'(eq1_q);
			fcl_pkg::B_EQ2:    mul_b = fcl_pkg::MUL_B_W'(eq2_q);
			fcl_pkg::B_HALF:   mul_b = fcl_pkg::HALF_SQRT3_Q24;
			fcl_pkg::B_UNIT23: mul_b = fcl_pkg::UNIT_Q23;
			default:           mul_b = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			uop_q <= 5'd0;
		end else begin
			v_s1 <= ctl.issue;
			if (item_xfer) begin
				uop_q <= 5'd0;
			end else if (ctl.issue) begin
				uop_q <= uop_q + 5'd1;
			end else if (ctl.div_end && div_sel_q) begin
				uop_q <= fcl_pkg::UOP_INV;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.issue) begin
			prod_s1 <= mul_a * mul_b;
			uop_s1  <= uop;
		end
	end

	assign acc_base = uop_s1.first ? fcl_pkg::round_seed(uop_s1.dst) : acc_q;
	assign acc_new  = uop_s1.sub ? acc_base - fcl_pkg::ACC_W'(prod_s1)
		: acc_base + fcl_pkg::ACC_W'(prod_s1);

	// PID close-out: add the increment to the last output, saturate, clamp
	logic signed [52:0] pid_sum;
	logic signed [31:0] pid_y;
	logic signed [32:0] lim_sel, pid_y33;
	logic signed [23:0] v_clamped;

	assign pid_sum = 53'(uop_s1.dst == fcl_pkg::D_PIDD ? yd_q : yq_q)
		+ 53'($signed(acc_new[67:16]));
	assign pid_y = (pid_sum > 53'sd2147483647) ? 32'sh7FFFFFFF
		: (pid_sum < -53'sd2147483648) ? 32'sh80000000 : pid_sum[31:0];
	assign lim_sel = $signed({10'd0, (uop_s1.dst == fcl_pkg::D_PIDD) ? dlim_q : qlim_q});
	assign pid_y33 = 33'(pid_y);
	assign v_clamped = (pid_y33 > lim_sel) ? 24'(lim_sel)
		: (pid_y33 < -lim_sel) ? 24'(-lim_sel) : pid_y[23:0];

	always_ff @(posedge clk) begin
		if (v_s1) begin
			acc_q <= acc_new;
		end
		if (v_s1 && uop_s1.last) begin
			case (uop_s1.dst)
				fcl_pkg::D_BETA:   beta_q   <= $signed(acc_new[55:30]);
				fcl_pkg::D_ID:     id_q     <= fcl_pkg::sat24($signed(acc_new[67:24]));
				fcl_pkg::D_IQ:     iq_q     <= fcl_pkg::sat24($signed(acc_new[67:24]));
				fcl_pkg::D_VALPHA: valpha_q <= $signed(acc_new[63:24]);
				fcl_pkg::D_VBETA:  vbeta_q  <= $signed(acc_new[63:24]);
				fcl_pkg::D_VC:     vc_q     <= $signed(acc_new[63:24]);
				default: ;
			endcase
		end
		// voltage modes carry the setpoints and report zero current
		if (item_xfer) begin
			item_q <= item;
			id_q   <= '0;
			iq_q   <= '0;
			vd_q   <= item.d_voltage_target;
			vq_q   <= item.q_voltage_target;
		end else if (v_s1 && uop_s1.last && uop_s1.dst == fcl_pkg::D_PIDD) begin
			vd_q <= v_clamped;
		end else if (v_s1 && uop_s1.last && uop_s1.dst == fcl_pkg::D_PIDQ) begin
			vq_q <= v_clamped;
		end
	end

	// PID histories; cleared on request in every mode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ed1_q <= '0;
			ed2_q <= '0;
			yd_q  <= '0;
			eq1_q <= '0;
			eq2_q <= '0;
			yq_q  <= '0;
		end else if (item_xfer && item.clear_pid) begin
			ed1_q <= '0;
			ed2_q <= '0;
			yd_q  <= '0;
			eq1_q <= '0;
			eq2_q <= '0;
			yq_q  <= '0;
		end else if (v_s1 && uop_s1.last && uop_s1.dst == fcl_pkg::D_PIDD) begin
			ed2_q <= ed1_q;
			ed1_q <= ed;
			yd_q  <= pid_y;
		end else if (v_s1 && uop_s1.last && uop_s1.dst == fcl_pkg::D_PIDQ) begin
			eq2_q <= eq1_q;
			eq1_q <= eq;
			yq_q  <= pid_y;
		end
	end

	// ------------------------------------------------------------------------
	// Divider: |v| * 2^30 / bus, one quotient bit per cycle, truncated toward
	// zero and saturated to +-128.0 in Q30. A quotient that would reach 2^38
	// is caught up front and skips the bit steps.
	// ------------------------------------------------------------------------
	logic [22:0] div_bus;
	logic signed [23:0] div_v;
	logic [23:0] div_abs;
	logic [23:0] rem2;
	logic        rem_ge;
	logic [fcl_pkg::DIV_Q_W-1:0] quo_c;
	logic signed [fcl_pkg::VN_W-1:0] vn;

	assign div_bus = (item_q.bus_voltage == 23'd0) ? 23'd1 : item_q.bus_voltage;
	assign div_v   = div_sel_q ? vq_q : vd_q;
	assign div_abs = div_v[23] ? 24'(-div_v) : 24'(div_v);
	assign rem2    = {rem_q, nsh_q[fcl_pkg::DIV_Q_W-1]};
	assign rem_ge  = rem2 >= {1'b0, div_bus};
	assign quo_c   = (ovf_q || quo_q > fcl_pkg::NORM_LIMIT) ? fcl_pkg::NORM_LIMIT : quo_q;
	assign vn      = neg_q ? -$signed(fcl_pkg::VN_W'(quo_c)) : $signed(fcl_pkg::VN_W'(quo_c));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_sel_q <= 1'b0;
			dc_q      <= 6'd0;
		end else begin
			if (item_xfer) begin
				div_sel_q <= 1'b0;
			end else if (ctl.div_end) begin
				div_sel_q <= ~div_sel_q;
			end
			if (ctl.div_init) begin
				dc_q <= 6'd0;
			end else if (ctl.div_step) begin
				dc_q <= dc_q + 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.div_init) begin
			neg_q <= div_v[23];
			ovf_q <= {7'd0, div_abs[23:8]} >= div_bus;
			rem_q <= {7'd0, div_abs[23:8]};
			nsh_q <= {div_abs[7:0], 30'd0};
			quo_q <= '0;
		end else if (ctl.div_step && !ovf_q) begin
			rem_q <= rem_ge ? 23'(rem2 - {1'b0, div_bus}) : rem2[22:0];
			nsh_q <= nsh_q << 1;
			quo_q <= {quo_q[fcl_pkg::DIV_Q_W-2:0], rem_ge};
		end
		if (ctl.div_end) begin
			if (div_sel_q) vqn_q <= vn;
			else vdn_q <= vn;
		end
	end

	// ------------------------------------------------------------------------
	// Result: second phase is minus the sum of the other two; hold the result
	// until the output side takes it
	// ------------------------------------------------------------------------
	logic signed [fcl_pkg::DUTY_W-1:0] va_w, vb_w, vc_w;

	assign va_w = fcl_pkg::DUTY_W'(valpha_q);
	assign vc_w = fcl_pkg::DUTY_W'(vc_q);
	assign vb_w = -va_w - vc_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (ctl.fin_load) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.fin_load) begin
			result_q.duty_a    <= fcl_pkg::duty_of(va_w);
			result_q.duty_b    <= fcl_pkg::duty_of(vb_w);
			result_q.duty_c    <= fcl_pkg::duty_of(vc_w);
			result_q.d_current <= id_q;
			result_q.q_current <= iq_q;
			result_q.d_voltage <= vd_q;
			result_q.q_voltage <= vq_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef SYNTHESIS
	a_take_starts_cordic: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> state_q == fcl_pkg::ST_CORDIC)
		else $error("accepted item did not start the CORDIC");

	a_rem_below_bus: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == fcl_pkg::ST_DIV_STEP && !ovf_q |-> rem_q < div_bus)
		else $error("divider remainder reached the divisor");

	a_acc_follows_issue: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> $past(state_q) == fcl_pkg::ST_MAC)
		else $error("accumulate without a product issued");

	a_fin_loads_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == fcl_pkg::ST_FIN && !result_valid_q |=> result_valid_q)
		else $error("finished update did not load the result register");
`endif

endmodule
